/* src/rbf_pkg.sv */
// rbf_pkg: shared types and constants for the rgba 3x3 box filter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package rbf_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int CFG_W      = 13;   // configuration data width
  localparam int CFG_IDX_W  = 1;
  localparam int CH_W       = 8;    // bits per color channel
  localparam int NUM_CH     = 4;
  localparam int PIX_W      = CH_W * NUM_CH;
  localparam int NUM_TAPS   = 9;
  localparam int POS_W      = 12;   // width of out_row / out_col
  localparam int SUM_W      = 12;   // holds 9 * 255

  localparam int RESET_WIDTH  = 3840;
  localparam int RESET_HEIGHT = 2160;
  localparam int MIN_DIM      = 3;

  // floor(x / 9) == (x * 7282) >> 16 for all x up to 9 * 255
  localparam int DIV9_MUL_W = 13;
  localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = DIV9_MUL_W'(7282);
  localparam int DIV9_SHIFT = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_index_t;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [NUM_TAPS-1:0][CH_W-1:0] tap_win_t;

  // line store controls for one pipeline slot
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ls_ctrl_t;

endpackage

/* src/rbf_line_store.sv */
// rbf_line_store: the two line memories (row above, two rows above) with read forwarding
// depends on rbf_pkg
`timescale 1ns / 1ps

module rbf_line_store #(
  parameter int DEPTH = rbf_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  rbf_pkg::ls_ctrl_t ctrl,
  input  logic [AW-1:0]    rd_addr,
  input  logic [AW-1:0]    wr_addr,
  input  rbf_pkg::pixel_t  wr_pix,
  output rbf_pkg::pixel_t  upper,
  output rbf_pkg::pixel_t  middle
);
  import rbf_pkg::*;

  pixel_t upper_mem  [DEPTH];
  pixel_t middle_mem [DEPTH];

  pixel_t upper_rd;
  pixel_t middle_rd;
  pixel_t upper_fwd;
  pixel_t middle_fwd;
  logic   fwd;

  // a column's middle entry moves up as the new pixel replaces it
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      upper_mem[wr_addr]  <= middle;
      middle_mem[wr_addr] <= wr_pix;
    end
  end

  // same-address write in the read cycle returns the old word, so forward it
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      upper_rd   <= upper_mem[rd_addr];
      middle_rd  <= middle_mem[rd_addr];
      fwd        <= ctrl.wr_en && (wr_addr == rd_addr);
      upper_fwd  <= middle;
      middle_fwd <= wr_pix;
    end
  end

  assign upper  = fwd ? upper_fwd  : upper_rd;
  assign middle = fwd ? middle_fwd : middle_rd;

endmodule

/* src/rbf_lane.sv */
// rbf_lane: one color channel of the 3x3 mean, nine-tap sum then divide by nine
// depends on rbf_pkg
`timescale 1ns / 1ps

module rbf_lane (
  input  logic                   clk,
  input  logic                   en,
  input  rbf_pkg::tap_win_t      taps,
  output logic [rbf_pkg::CH_W-1:0] mean
);
  import rbf_pkg::*;

  logic [SUM_W-1:0] sum_next;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] pair0, pair1, pair2, pair3;
  logic [SUM_W+DIV9_MUL_W-1:0] product;

  // balanced adder tree
  always_comb begin
    pair0    = SUM_W'(taps[0]) + SUM_W'(taps[1]);
    pair1    = SUM_W'(taps[2]) + SUM_W'(taps[3]);
    pair2    = SUM_W'(taps[4]) + SUM_W'(taps[5]);
    pair3    = SUM_W'(taps[6]) + SUM_W'(taps[7]);
    sum_next = (pair0 + pair1) + (pair2 + pair3) + SUM_W'(taps[8]);
  end

  // divide by nine via reciprocal multiply
  assign product = (SUM_W+DIV9_MUL_W)'(sum) * (SUM_W+DIV9_MUL_W)'(DIV9_MUL);

  always_ff @(posedge clk) begin
    if (en) begin
      sum  <= sum_next;
      mean <= product[DIV9_SHIFT +: CH_W];
    end
  end

endmodule

/* src/rgba_box_filter_3x3_core.sv */
// Streaming 3x3 box filter over RGBA pixels: accepts one pixel per clock in raster order
// and returns the truncated mean of each interior pixel's nine neighbors, formed through
// stage 1, stage 2 and the output register. The rate of one pixel per clock is set by the
// line memories, each read once and written once per transaction through separate read and
// write ports; a pixel is taken in the same cycle as a finished result leaves, and only a held
// output stalls the stream. Border pixels produce no result. Frame size comes from image_width
// (index 0) and image_height (index 1), clamped to [3, MAX_WIDTH] and [3, MAX_HEIGHT]; write
// them only while the block is idle. frame_start restarts the position at row 0, column 0;
// without it the position wraps at the end of each frame. The line memories need no clearing
// after reset.
// depends on rbf_pkg, rbf_line_store, rbf_lane
`timescale 1ns / 1ps

module rgba_box_filter_3x3_core #(
  parameter int MAX_WIDTH  = rbf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rbf_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [rbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbf_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           frame_start,
  input  logic [rbf_pkg::CH_W-1:0]       red_in,
  input  logic [rbf_pkg::CH_W-1:0]       green_in,
  input  logic [rbf_pkg::CH_W-1:0]       blue_in,
  input  logic [rbf_pkg::CH_W-1:0]       alpha_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rbf_pkg::CH_W-1:0]       red_out,
  output logic [rbf_pkg::CH_W-1:0]       green_out,
  output logic [rbf_pkg::CH_W-1:0]       blue_out,
  output logic [rbf_pkg::CH_W-1:0]       alpha_out,
  output logic [rbf_pkg::POS_W-1:0]      out_row,
  output logic [rbf_pkg::POS_W-1:0]      out_col,
  output logic                           frame_done
);
  import rbf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  // configuration
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [WW-1:0]    w;
  logic [HW-1:0]    h;

  // position
  logic [CW-1:0] col_count, col_count_next;
  logic [RW-1:0] row_count, row_count_next;
  logic [CW-1:0] col_a;
  logic [RW-1:0] row_a;
  logic [HW-1:0] row_b;
  logic [WW-1:0] col_n;
  logic [HW-1:0] row_c;
  logic [CW-1:0] col_m1;
  logic [RW-1:0] row_m1;
  logic          emit0;
  logic          done0;

  logic accept;
  logic advance;

  // stage 1
  logic              s1_valid;
  logic              s1_emit;
  logic              s1_done;
  logic [CW-1:0]     s1_addr;
  logic [POS_W-1:0]  s1_row;
  logic [POS_W-1:0]  s1_col;
  pixel_t            s1_pix;
  pixel_t            upper;
  pixel_t            middle;
  pixel_t            win_c1 [3];
  pixel_t            win_c2 [3];
  pixel_t            win    [NUM_TAPS];
  ls_ctrl_t          ls_ctrl;

  // stage 2
  logic              s2_valid;
  logic              s2_done;
  logic [POS_W-1:0]  s2_row;
  logic [POS_W-1:0]  s2_col;

  logic [NUM_CH-1:0][CH_W-1:0] lane_mean;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W'(RESET_WIDTH);
      image_height <= CFG_W'(RESET_HEIGHT);
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(image_width) < MIN_DIM)
      w = WW'(MIN_DIM);
    else if (32'(image_width) > MAX_WIDTH)
      w = WW'(MAX_WIDTH);
    else
      w = WW'(image_width);
    if (32'(image_height) < MIN_DIM)
      h = HW'(MIN_DIM);
    else if (32'(image_height) > MAX_HEIGHT)
      h = HW'(MAX_HEIGHT);
    else
      h = HW'(image_height);
  end

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && in_ready;

  // position of this pixel, and of the next one
  always_comb begin
    logic [CW-1:0] col_pre;
    logic [RW-1:0] row_pre;
    col_pre = frame_start ? '0 : col_count;
    row_pre = frame_start ? '0 : row_count;
    // wrap first if the frame size shrank under the position
    if (WW'(col_pre) >= w) begin
      col_a = '0;
      row_b = HW'(row_pre) + 1'b1;
    end else begin
      col_a = col_pre;
      row_b = HW'(row_pre);
    end
    row_a  = (row_b >= h) ? '0 : RW'(row_b);
    emit0  = (row_a >= RW'(2)) && (col_a >= CW'(2));
    done0  = (HW'(row_a) == h - 1'b1) && (WW'(col_a) == w - 1'b1);
    col_m1 = col_a - 1'b1;
    row_m1 = row_a - 1'b1;

    col_n = WW'(col_a) + 1'b1;
    row_c = HW'(row_a) + 1'b1;
    if (col_n >= w) begin
      col_count_next = '0;
      row_count_next = (row_c >= h) ? '0 : RW'(row_c);
    end else begin
      col_count_next = CW'(col_n);
      row_count_next = row_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // stage 1: line store read returns, window is formed
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit <= emit0;
      s1_done <= done0;
      s1_addr <= col_a;
      s1_row  <= POS_W'(row_m1);
      s1_col  <= POS_W'(col_m1);
      s1_pix  <= {alpha_in, blue_in, green_in, red_in};
    end
  end

  // a stage-1 transaction leaves whenever the pipeline advances, so its write lands then
  assign ls_ctrl.rd_en = accept;
  assign ls_ctrl.wr_en = s1_valid && advance;

  rbf_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk     (clk),
    .ctrl    (ls_ctrl),
    .rd_addr (col_a),
    .wr_addr (s1_addr),
    .wr_pix  (s1_pix),
    .upper   (upper),
    .middle  (middle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        win_c1[i] <= '0;
        win_c2[i] <= '0;
      end
    end else if (ls_ctrl.wr_en) begin
      for (int i = 0; i < 3; i++)
        win_c2[i] <= win_c1[i];
      win_c1[0] <= upper;
      win_c1[1] <= middle;
      win_c1[2] <= s1_pix;
    end
  end

  always_comb begin
    win[0] = win_c2[0];
    win[1] = win_c2[1];
    win[2] = win_c2[2];
    win[3] = win_c1[0];
    win[4] = win_c1[1];
    win[5] = win_c1[2];
    win[6] = upper;
    win[7] = middle;
    win[8] = s1_pix;
  end

  // one lane per channel: sum in stage 2, mean in the output stage
  for (genvar l = 0; l < NUM_CH; l++) begin : g_lane
    tap_win_t taps;

    always_comb begin
      for (int k = 0; k < NUM_TAPS; k++)
        taps[k] = win[k][l*CH_W +: CH_W];
    end

    rbf_lane u_lane (
      .clk  (clk),
      .en   (advance),
      .taps (taps),
      .mean (lane_mean[l])
    );
  end

  // stage 2 and output stage carry position beside the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s2_valid  <= s1_valid && s1_emit;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_done    <= s1_done;
      s2_row     <= s1_row;
      s2_col     <= s1_col;
      frame_done <= s2_done;
      out_row    <= s2_row;
      out_col    <= s2_col;
    end
  end

  assign red_out   = lane_mean[0];
  assign green_out = lane_mean[1];
  assign blue_out  = lane_mean[2];
  assign alpha_out = lane_mean[3];

  a_frame_start_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && frame_start |=> col_count == CW'(1) && row_count == '0)
    else $error("frame_start did not restart the position");

  a_s2_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(s2_valid) |-> $past(s1_valid && s1_emit))
    else $error("stage 2 filled without an interior pixel");

  a_write_only_on_advance: assert property (@(posedge clk) disable iff (rst)
    ls_ctrl.wr_en |-> s1_valid && (!out_valid || out_ready))
    else $error("line store written while the pipeline is stalled");

endmodule
